// ----- sv/wcm_pkg.sv -----
package wcm_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam int DistW   = 24;
  localparam int ConfW   = 16;
  localparam int ValW    = 24;
  localparam int FracW   = 24;
  localparam int RatioW  = 48;
  localparam int RatQW   = ConfW + FracW;
  localparam int WeightW = FracW + 1;
  localparam int WsumW   = WeightW + AddrW;
  localparam int MagSqW  = 2 * ValW;
  localparam int SpreadW = 15;

  localparam int DivNumW  = 64;
  localparam int DivDenW  = RatioW;
  localparam int DivStepW = $clog2(DivNumW + 1);

  localparam int SqrtInW   = 64;
  localparam int SqrtOutW  = SqrtInW / 2;
  localparam int SqrtStepW = $clog2(SqrtOutW + 1);

  localparam int CordSteps = 16;
  localparam int CordStepW = $clog2(CordSteps);
  localparam int CordW     = ValW + 12;
  localparam int AngW      = 21;
  localparam int PhaseW    = 16;
  localparam int CordPi    = 205887;
  localparam int PiQ       = 25736;
  localparam int TwoPiQ    = 51472;

  localparam int MulAW = WeightW;
  localparam int MulBW = 31;
  localparam int ProdW = MulAW + 1 + MulBW;

  typedef enum logic [4:0] {
    S_IDLE, S_RATIO, S_FIN,
    S_P1_RD, S_P1_RAT, S_P1_RATW, S_P1_WW, S_P1_SQ, S_P1_SQS, S_P1_SQW, S_P1_MAC,
    S_REF, S_REFS, S_REFW,
    S_P2_RD, S_P2_COR, S_P2_CW, S_P2_MUL,
    S_SPR, S_SPRW, S_SQ2W, S_OUT
  } wcm_state_t;

  function automatic logic [AngW-1:0] atan_step(input logic [CordStepW-1:0] i);
    logic [AngW-1:0] v;
    case (i)
      4'd0:    v = AngW'(51472);
      4'd1:    v = AngW'(30385);
      4'd2:    v = AngW'(16055);
      4'd3:    v = AngW'(8150);
      4'd4:    v = AngW'(4091);
      4'd5:    v = AngW'(2047);
      4'd6:    v = AngW'(1024);
      4'd7:    v = AngW'(512);
      4'd8:    v = AngW'(256);
      4'd9:    v = AngW'(128);
      4'd10:   v = AngW'(64);
      4'd11:   v = AngW'(32);
      4'd12:   v = AngW'(16);
      4'd13:   v = AngW'(8);
      4'd14:   v = AngW'(4);
      4'd15:   v = AngW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/wcm_div.sv -----
module wcm_div import wcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DivNumW-1:0]  num,
  input  logic [DivDenW-1:0]  den,
  input  logic [DivStepW-1:0] steps,
  output logic                done,
  output logic [DivNumW-1:0]  quo
);

  logic                busy_r, done_r;
  logic [DivStepW-1:0] left_r;
  logic [DivNumW-1:0]  num_r, quo_r;
  logic [DivDenW-1:0]  den_r, rem_r;
  logic [DivDenW:0]    trial, diff;
  logic                ge;

  assign trial = {rem_r, num_r[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        left_r <= steps;
      end else if (busy_r) begin
        left_r <= left_r - 1'b1;
        if (left_r == DivStepW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DivNumW-2:0], 1'b0};
      rem_r <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_r <= {quo_r[DivNumW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- sv/wcm_sqrt.sv -----
module wcm_sqrt import wcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SqrtInW-1:0]  rad,
  output logic                done,
  output logic [SqrtOutW-1:0] root
);

  logic                 busy_r, done_r;
  logic [SqrtStepW-1:0] left_r;
  logic [SqrtInW-1:0]   rad_r;
  logic [SqrtOutW-1:0]  root_r;
  logic [SqrtOutW+1:0]  rem_r;
  logic [SqrtOutW+3:0]  trem, trial, diff;
  logic                 ge;

  assign trem  = {rem_r, rad_r[SqrtInW-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = trem >= trial;
  assign diff  = trem - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        left_r <= SqrtStepW'(SqrtOutW);
      end else if (busy_r) begin
        left_r <= left_r - 1'b1;
        if (left_r == SqrtStepW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SqrtInW-3:0], 2'b00};
      rem_r  <= ge ? diff[SqrtOutW+1:0] : trem[SqrtOutW+1:0];
      root_r <= {root_r[SqrtOutW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- sv/wcm_cordic.sv -----
module wcm_cordic import wcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [ValW-1:0]   y_in,
  input  logic signed [ValW-1:0]   x_in,
  output logic                     done,
  output logic signed [PhaseW-1:0] angle
);

  logic                        busy_r, done_r;
  logic [CordStepW-1:0]        step_r;
  logic signed [CordW-1:0]     x_r, y_r, xs, ys, dx, dy, x_nxt, y_nxt;
  logic signed [AngW-1:0]      z_r, z0, z_nxt, zr;
  logic signed [PhaseW-1:0]    angle_r, fin;
  logic                        zero_in, last;

  assign zero_in = (x_in == '0) && (y_in == '0);
  assign last    = step_r == CordStepW'(CordSteps - 1);

  always_comb begin
    xs = {{(CordW-ValW-8){x_in[ValW-1]}}, x_in, 8'b0};
    ys = {{(CordW-ValW-8){y_in[ValW-1]}}, y_in, 8'b0};
    z0 = '0;
    if (x_in < 0) begin
      xs = -xs;
      ys = -ys;
      z0 = (y_in >= 0) ? AngW'(CordPi) : -AngW'(CordPi);
    end
  end

  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    if (y_r > 0) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + $signed(atan_step(step_r));
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - $signed(atan_step(step_r));
    end
    zr = (z_nxt + AngW'(4)) >>> 3;
    if (zr > AngW'(PiQ)) begin
      fin = PhaseW'(PiQ);
    end else if (zr < -AngW'(PiQ)) begin
      fin = -PhaseW'(PiQ);
    end else begin
      fin = zr[PhaseW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= !zero_in;
        done_r <= zero_in;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      x_r     <= xs;
      y_r     <= ys;
      z_r     <= z0;
      angle_r <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      if (last) begin
        angle_r <= fin;
      end
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

// ----- sv/weighted_complex_merge_unit.sv -----
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid, in_stall   | distance, confidence, value_re, value_im, group_end
// out_     | output    | out_valid, out_stall | mean_re, mean_im, mean_magnitude, mean_confidence,
//          |           |                      | mean_distance, phase_spread
//
// A point that does not close its group costs one 40-step divide of confidence by distance.
// Closing a group makes a first pass over the stored points (two divides, a square root and a
// row of multiplies per point), finds the reference phase with one CORDIC, makes a second pass
// (one CORDIC and two multiplies per point) and ends with a divide and a square root.
// Reset is synchronous and active low; it empties the group and no memory clear is needed.
// One item is in work at a time: in_stall is high from acceptance until the unit is idle again.
// A result is held on the output until the transfer completes.
module weighted_complex_merge_unit import wcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DistW-1:0]         in_distance,
  input  logic [ConfW-1:0]         in_confidence,
  input  logic signed [ValW-1:0]   in_value_re,
  input  logic signed [ValW-1:0]   in_value_im,
  input  logic                     in_group_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValW-1:0]   out_mean_re,
  output logic signed [ValW-1:0]   out_mean_im,
  output logic [ValW-1:0]          out_mean_magnitude,
  output logic [ConfW-1:0]         out_mean_confidence,
  output logic [DistW-1:0]         out_mean_distance,
  output logic [SpreadW-1:0]       out_phase_spread
);

  localparam int AccW = ProdW;

  wcm_state_t state_r, state_nxt;

  logic [CntW-1:0]   cnt_r, n_r, j_r;
  logic [2:0]        k_r;
  logic [RatioW-1:0] total_r;
  logic              end_r;

  logic [DistW-1:0]   dist_mem [MaxPoints];
  logic [ConfW-1:0]   conf_mem [MaxPoints];
  logic [ValW-1:0]    re_mem   [MaxPoints];
  logic [ValW-1:0]    im_mem   [MaxPoints];
  logic [WeightW-1:0] w_mem    [MaxPoints];
  logic [DistW-1:0]   rd_dist_r;
  logic [ConfW-1:0]   rd_conf_r;
  logic signed [ValW-1:0] rd_re_r, rd_im_r;
  logic [WeightW-1:0] rd_w_r;

  logic [WeightW-1:0]       w_r;
  logic [MagSqW-1:0]        magsq_r;
  logic [ValW-1:0]          mag_r;
  logic signed [AccW-1:0]   sre_r, sim_r;
  logic [AccW-1:0]          smag_r, sconf_r, sdist_r;
  logic [63:0]              s_r;
  logic [WsumW-1:0]         wsum_r;
  logic signed [PhaseW-1:0] pref_r;
  logic [PhaseW-1:0]        res_r;

  logic signed [ValW-1:0] mean_re_r, mean_im_r;
  logic [ValW-1:0]        mean_mag_r;
  logic [ConfW-1:0]       mean_conf_r;
  logic [DistW-1:0]       mean_dist_r;
  logic [SpreadW-1:0]     spread_r;

  logic [MulAW-1:0]        mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_r;

  logic                div_start, div_done;
  logic [DivNumW-1:0]  div_num, div_quo;
  logic [DivDenW-1:0]  div_den;
  logic [DivStepW-1:0] div_steps;
  logic                sq_start, sq_done;
  logic [SqrtInW-1:0]  sq_rad;
  logic [SqrtOutW-1:0] sq_root;
  logic                cd_start, cd_done;
  logic signed [ValW-1:0]   cd_y, cd_x;
  logic signed [PhaseW-1:0] cd_angle;

  logic               accept, keep, last_pt;
  logic [RatioW:0]    total_sum;
  logic [64:0]        s_sum;
  logic [PhaseW-1:0]  res_calc;
  logic [ValW-1:0]    abs_re, abs_im;

  function automatic logic [DistW-1:0] eff_dist(input logic [DistW-1:0] d);
    return (d == '0) ? DistW'(1) : d;
  endfunction

  function automatic logic signed [ValW-1:0] rnd_s(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] t;
    logic signed [ValW-1:0] r;
    t = (a + AccW'(1 << (FracW - 1))) >>> FracW;
    if (t > AccW'(8388607)) begin
      r = ValW'(8388607);
    end else if (t < -AccW'(8388608)) begin
      r = -ValW'(8388608);
    end else begin
      r = t[ValW-1:0];
    end
    return r;
  endfunction

  function automatic logic [AccW-1:0] rnd_u(input logic [AccW-1:0] a,
                                            input logic [AccW-1:0] maxv);
    logic [AccW-1:0] t;
    t = (a + AccW'(1 << (FracW - 1))) >> FracW;
    return (t > maxv) ? maxv : t;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign keep      = cnt_r < CntW'(MaxPoints);
  assign last_pt   = (j_r + 1'b1) == n_r;
  assign total_sum = {1'b0, total_r} + (RatioW+1)'(div_quo[RatQW-1:0]);
  assign s_sum     = {1'b0, s_r} + 65'($unsigned(prod_r));
  assign abs_re    = rd_re_r[ValW-1] ? ValW'(-rd_re_r) : ValW'(rd_re_r);
  assign abs_im    = rd_im_r[ValW-1] ? ValW'(-rd_im_r) : ValW'(rd_im_r);

  always_comb begin
    logic signed [PhaseW+2:0] p, q, d1, d2;
    logic [PhaseW+2:0] a1, a2;
    p  = (PhaseW+3)'(cd_angle);
    q  = (cd_angle > pref_r) ? p - (PhaseW+3)'(TwoPiQ) : p + (PhaseW+3)'(TwoPiQ);
    d1 = p - (PhaseW+3)'(pref_r);
    d2 = q - (PhaseW+3)'(pref_r);
    a1 = d1[PhaseW+2] ? (PhaseW+3)'(-d1) : (PhaseW+3)'(d1);
    a2 = d2[PhaseW+2] ? (PhaseW+3)'(-d2) : (PhaseW+3)'(d2);
    res_calc = (a1 < a2) ? a1[PhaseW-1:0] : a2[PhaseW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (keep) begin
            state_nxt = S_RATIO;
          end else if (in_group_end) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RATIO:   if (div_done) state_nxt = end_r ? S_FIN : S_IDLE;
      S_FIN:     state_nxt = (total_r == '0) ? S_OUT : S_P1_RD;
      S_P1_RD:   state_nxt = S_P1_RAT;
      S_P1_RAT:  state_nxt = S_P1_RATW;
      S_P1_RATW: if (div_done) state_nxt = S_P1_WW;
      S_P1_WW:   if (div_done) state_nxt = S_P1_SQ;
      S_P1_SQ:   if (k_r == 3'd2) state_nxt = S_P1_SQS;
      S_P1_SQS:  state_nxt = S_P1_SQW;
      S_P1_SQW:  if (sq_done) state_nxt = S_P1_MAC;
      S_P1_MAC:  if (k_r == 3'd5) state_nxt = last_pt ? S_REF : S_P1_RD;
      S_REF:     state_nxt = S_REFS;
      S_REFS:    state_nxt = S_REFW;
      S_REFW:    if (cd_done) state_nxt = S_P2_RD;
      S_P2_RD:   state_nxt = S_P2_COR;
      S_P2_COR:  state_nxt = S_P2_CW;
      S_P2_CW:   if (cd_done) state_nxt = S_P2_MUL;
      S_P2_MUL:  if (k_r == 3'd2) state_nxt = last_pt ? S_SPR : S_P2_RD;
      S_SPR:     state_nxt = (wsum_r == '0) ? S_OUT : S_SPRW;
      S_SPRW:    if (div_done) state_nxt = S_SQ2W;
      S_SQ2W:    if (sq_done) state_nxt = S_OUT;
      S_OUT:     if (!out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != S_IDLE;
    out_valid = state_r == S_OUT;
    div_start = 1'b0;
    div_num   = s_r;
    div_den   = DivDenW'(wsum_r);
    div_steps = DivStepW'(DivNumW);
    sq_start  = 1'b0;
    sq_rad    = div_quo;
    cd_start  = 1'b0;
    cd_y      = rd_im_r;
    cd_x      = rd_re_r;
    mul_a     = w_r;
    mul_b     = '0;
    case (state_r)
      S_IDLE: begin
        div_start = in_valid && keep;
        div_num   = {in_confidence, (DivNumW-ConfW)'(0)};
        div_den   = DivDenW'(eff_dist(in_distance));
        div_steps = DivStepW'(RatQW);
      end
      S_P1_RAT: begin
        div_start = 1'b1;
        div_num   = {rd_conf_r, (DivNumW-ConfW)'(0)};
        div_den   = DivDenW'(eff_dist(rd_dist_r));
        div_steps = DivStepW'(RatQW);
      end
      S_P1_RATW: begin
        div_start = div_done;
        div_num   = {div_quo[RatQW-1:0], FracW'(0)};
        div_den   = total_r;
      end
      S_P1_SQ: begin
        mul_a = (k_r == 3'd0) ? MulAW'(abs_re) : MulAW'(abs_im);
        mul_b = (k_r == 3'd0) ? MulBW'(abs_re) : MulBW'(abs_im);
      end
      S_P1_SQS: begin
        sq_start = 1'b1;
        sq_rad   = SqrtInW'(magsq_r);
      end
      S_P1_MAC: begin
        case (k_r)
          3'd0:    mul_b = MulBW'(rd_re_r);
          3'd1:    mul_b = MulBW'(rd_im_r);
          3'd2:    mul_b = MulBW'(mag_r);
          3'd3:    mul_b = MulBW'(rd_conf_r);
          3'd4:    mul_b = MulBW'(eff_dist(rd_dist_r));
          default: mul_b = '0;
        endcase
      end
      S_REFS: begin
        cd_start = 1'b1;
        cd_y     = mean_im_r;
        cd_x     = mean_re_r;
      end
      S_P2_COR: cd_start = 1'b1;
      S_P2_MUL: begin
        mul_a = (k_r == 3'd0) ? MulAW'(res_r) : rd_w_r;
        mul_b = (k_r == 3'd0) ? MulBW'(res_r) : prod_r[MulBW-1:0];
      end
      S_SPR:  div_start = wsum_r != '0;
      S_SPRW: sq_start = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ProdW'($signed({1'b0, mul_a})) * ProdW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      dist_mem[cnt_r[AddrW-1:0]] <= in_distance;
      conf_mem[cnt_r[AddrW-1:0]] <= in_confidence;
      re_mem[cnt_r[AddrW-1:0]]   <= in_value_re;
      im_mem[cnt_r[AddrW-1:0]]   <= in_value_im;
    end
    if (state_r == S_P1_WW && div_done) begin
      w_mem[j_r[AddrW-1:0]] <= div_quo[WeightW-1:0];
    end
    rd_dist_r <= dist_mem[j_r[AddrW-1:0]];
    rd_conf_r <= conf_mem[j_r[AddrW-1:0]];
    rd_re_r   <= re_mem[j_r[AddrW-1:0]];
    rd_im_r   <= im_mem[j_r[AddrW-1:0]];
    rd_w_r    <= w_mem[j_r[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            end_r <= in_group_end;
          end
        end
        S_RATIO: begin
          if (div_done) begin
            total_r <= total_sum[RatioW] ? '1 : total_sum[RatioW-1:0];
            cnt_r   <= cnt_r + 1'b1;
          end
        end
        S_FIN: begin
          n_r     <= cnt_r;
          cnt_r   <= '0;
          j_r     <= '0;
          sre_r   <= '0;
          sim_r   <= '0;
          smag_r  <= '0;
          sconf_r <= '0;
          sdist_r <= '0;
          if (total_r == '0) begin
            mean_re_r   <= '0;
            mean_im_r   <= '0;
            mean_mag_r  <= '0;
            mean_conf_r <= '0;
            mean_dist_r <= '0;
            spread_r    <= '0;
          end
        end
        S_P1_WW: begin
          if (div_done) begin
            w_r <= div_quo[WeightW-1:0];
            k_r <= '0;
          end
        end
        S_P1_SQ: begin
          k_r <= k_r + 1'b1;
          if (k_r == 3'd1) magsq_r <= prod_r[MagSqW-1:0];
          if (k_r == 3'd2) magsq_r <= magsq_r + prod_r[MagSqW-1:0];
        end
        S_P1_SQW: begin
          if (sq_done) begin
            mag_r <= sq_root[ValW-1:0];
            k_r   <= '0;
          end
        end
        S_P1_MAC: begin
          k_r <= k_r + 1'b1;
          case (k_r)
            3'd1:    sre_r   <= sre_r + prod_r;
            3'd2:    sim_r   <= sim_r + prod_r;
            3'd3:    smag_r  <= smag_r + $unsigned(prod_r);
            3'd4:    sconf_r <= sconf_r + $unsigned(prod_r);
            3'd5: begin
              sdist_r <= sdist_r + $unsigned(prod_r);
              j_r     <= j_r + 1'b1;
            end
            default: ;
          endcase
        end
        S_REF: begin
          mean_re_r   <= rnd_s(sre_r);
          mean_im_r   <= rnd_s(sim_r);
          mean_mag_r  <= ValW'(rnd_u(smag_r, AccW'({ValW{1'b1}})));
          mean_conf_r <= ConfW'(rnd_u(sconf_r, AccW'({ConfW{1'b1}})));
          mean_dist_r <= DistW'(rnd_u(sdist_r, AccW'({DistW{1'b1}})));
          total_r     <= '0;
          j_r         <= '0;
          s_r         <= '0;
          wsum_r      <= '0;
        end
        S_REFW: if (cd_done) pref_r <= cd_angle;
        S_P2_CW: begin
          if (cd_done) begin
            res_r <= res_calc;
            k_r   <= '0;
          end
        end
        S_P2_MUL: begin
          k_r <= k_r + 1'b1;
          if (k_r == 3'd2) begin
            s_r    <= s_sum[64] ? '1 : s_sum[63:0];
            wsum_r <= wsum_r + WsumW'(rd_w_r);
            j_r    <= j_r + 1'b1;
          end
        end
        S_SPR: if (wsum_r == '0) spread_r <= '0;
        S_SQ2W: begin
          if (sq_done) begin
            spread_r <= (sq_root > SqrtOutW'({SpreadW{1'b1}})) ? '1 : sq_root[SpreadW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  wcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo)
  );

  wcm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  wcm_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .y_in  (cd_y),
    .x_in  (cd_x),
    .done  (cd_done),
    .angle (cd_angle)
  );

  assign out_mean_re         = mean_re_r;
  assign out_mean_im         = mean_im_r;
  assign out_mean_magnitude  = mean_mag_r;
  assign out_mean_confidence = mean_conf_r;
  assign out_mean_distance   = mean_dist_r;
  assign out_phase_spread    = spread_r;

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while a result waits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxPoints)) else $error("point count beyond store depth");

  a_spread_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase_spread <= SpreadW'(PiQ)) else $error("phase spread beyond pi");

  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REF) |=> (total_r == '0)) else $error("ratio total not cleared");

endmodule
